// ----- hdl/jes_pkg.sv -----
// Shared types and constants for the JPEG EXIF segment stripper.
// Used by jes_parser and jpeg_exif_segment_stripper_top; no dependencies.

package jes_pkg;

	localparam int unsigned ResMax  = 5;
	localparam int unsigned HdrMax  = 4;
	localparam int unsigned PaddrW  = 3;
	localparam int unsigned PdataW  = 32;
	localparam int unsigned OutDataW = 16;

	localparam logic [7:0] StripReset = 8'hE1;
	localparam logic [7:0] CodeFf     = 8'hFF;
	localparam logic [7:0] CodeSoi    = 8'hD8;
	localparam logic [7:0] CodeSos    = 8'hDA;

	localparam logic RegStripCode = 1'b0;

	localparam logic KindData   = 1'b0;
	localparam logic KindStatus = 1'b1;

	typedef enum logic [3:0] {
		PH_SOI0,
		PH_SOI1,
		PH_MARK0,
		PH_MARK1,
		PH_LEN0,
		PH_LEN1,
		PH_PAYLOAD,
		PH_COPY,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_SOI    = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [2:0]              n;
		res_t [ResMax-1:0]       ent;
	} res_set_t;

endpackage

// ----- hdl/jes_parser.sv -----
// Segment parser: phase state and the per-byte step producing up to five beats.
// Depends on jes_pkg.

module jes_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        in_byte,
	input  logic              eof,
	input  logic [7:0]        strip_code,
	output jes_pkg::res_set_t res_set
);
	import jes_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  marker_q, marker_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] left_q, left_d;
	logic        drop_q, drop_d;
	status_t     stop_q, stop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOI0;
			left_q  <= '0;
			drop_q  <= 1'b0;
			stop_q  <= ST_DONE;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			drop_q  <= drop_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			marker_q <= marker_d;
			len_hi_q <= len_hi_d;
		end
	end

	always_comb begin
		logic [15:0] len;
		logic [15:0] len_m2;
		logic [15:0] left_dec;
		logic [7:0]  db [ResMax];
		logic [2:0]  nd;
		status_t     st;

		phase_d  = phase_q;
		marker_d = marker_q;
		len_hi_d = len_hi_q;
		left_d   = left_q;
		drop_d   = drop_q;
		stop_d   = stop_q;
		len      = {len_hi_q, in_byte};
		len_m2   = len - 16'd2;
		left_dec = (left_q == '0) ? '0 : left_q - 16'd1;
		nd       = '0;
		for (int i = 0; i < ResMax; i++) begin
			db[i] = '0;
		end

		unique case (phase_q)
			PH_SOI0: begin
				if (in_byte == CodeFf) begin
					phase_d = PH_SOI1;
				end else begin
					stop_d  = ST_NO_SOI;
					phase_d = PH_HALT;
				end
			end
			PH_SOI1: begin
				if (in_byte == CodeSoi) begin
					db[0]   = CodeFf;
					db[1]   = CodeSoi;
					nd      = 3'd2;
					phase_d = PH_MARK0;
				end else begin
					stop_d  = ST_NO_SOI;
					phase_d = PH_HALT;
				end
			end
			PH_MARK0: begin
				if (in_byte == CodeFf) begin
					phase_d = PH_MARK1;
				end else begin
					stop_d  = ST_MALFORMED;
					phase_d = PH_HALT;
				end
			end
			PH_MARK1: begin
				marker_d = in_byte;
				if (in_byte == CodeSos) begin
					db[0]   = CodeFf;
					db[1]   = CodeSos;
					nd      = 3'd2;
					phase_d = PH_COPY;
				end else begin
					phase_d = PH_LEN0;
				end
			end
			PH_LEN0: begin
				len_hi_d = in_byte;
				phase_d  = PH_LEN1;
			end
			PH_LEN1: begin
				if (len < 16'd2) begin
					stop_d  = ST_MALFORMED;
					phase_d = PH_HALT;
				end else begin
					drop_d = (marker_q == strip_code);
					left_d = len_m2;
					if (marker_q != strip_code) begin
						db[0] = CodeFf;
						db[1] = marker_q;
						db[2] = len_hi_q;
						db[3] = in_byte;
						nd    = 3'(HdrMax);
					end
					phase_d = (len_m2 == '0) ? PH_MARK0 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (!drop_q) begin
					db[0] = in_byte;
					nd    = 3'd1;
				end
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_MARK0;
				end
			end
			PH_COPY: begin
				db[0] = in_byte;
				nd    = 3'd1;
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase

		unique case (phase_d)
			PH_SOI0, PH_SOI1:          st = ST_NO_SOI;
			PH_MARK1, PH_LEN0, PH_LEN1: st = ST_MALFORMED;
			PH_HALT:                   st = stop_d;
			default:                   st = ST_DONE;
		endcase

		res_set.n = nd + {2'b0, eof};
		for (int i = 0; i < ResMax; i++) begin
			if (3'(i) < nd) begin
				res_set.ent[i] = '{kind: KindData, out_byte: db[i], status: ST_DONE, last: 1'b0};
			end else begin
				res_set.ent[i] = '{kind: KindStatus, out_byte: 8'h00, status: st, last: 1'b1};
			end
		end

		// start over for the next file
		if (eof) begin
			phase_d = PH_SOI0;
			left_d  = '0;
			drop_d  = 1'b0;
			stop_d  = ST_DONE;
		end
	end

endmodule

// ----- hdl/jpeg_exif_segment_stripper_top.sv -----
// A byte accepted from s_tdata is registered in the input stage; its beats then load the
// result buffer, which drives the output. Throughput: one byte per cycle while each byte
// yields at most one beat and m_tready is high; a byte that yields several beats (SOI,
// SOS, a kept segment's length byte, end of file) holds the input until the result buffer
// has drained them, up to five, one beat a cycle while m_tready is high. Reset: arst_n
// clears the input stage, the result buffer, the parser phase and sets strip_code to E1.

module jpeg_exif_segment_stripper_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jes_pkg::PaddrW-1:0]    paddr,
	input  logic [jes_pkg::PdataW-1:0]    pwdata,
	output logic [jes_pkg::PdataW-1:0]    prdata,
	output logic                          pready,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] in_byte
	input  logic                          s_tlast,   // end_of_file
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [jes_pkg::OutDataW-1:0]  m_tdata,   // [7:0] out_byte, [9:8] status
	output logic                          m_tuser,   // kind
	output logic                          m_tlast    // last
);
	import jes_pkg::*;

	logic       [7:0] strip_q;
	logic             in_v_s1;
	logic       [7:0] byte_s1;
	logic             eof_s1;
	res_t             buf_q [ResMax];
	logic       [2:0] rem_q;
	logic       [2:0] rd_q;
	res_set_t         res_set;
	res_t             cur;
	logic             drain;
	logic             drain_last;
	logic             step;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegStripCode) ? {{(PdataW-8){1'b0}}, strip_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= StripReset;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegStripCode) begin
			strip_q <= pwdata[7:0];
		end
	end

	// handshake
	assign drain      = m_tvalid && m_tready;
	assign drain_last = drain && (rem_q == 3'd1);
	assign step       = in_v_s1 && (rem_q == '0 || drain_last);
	assign s_tready   = !in_v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_tready) begin
			in_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	jes_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.in_byte    (byte_s1),
		.eof        (eof_s1),
		.strip_code (strip_q),
		.res_set    (res_set)
	);

	// result buffer: load a whole beat set, drain one beat a cycle while m_tready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (step) begin
			rem_q <= res_set.n;
			rd_q  <= '0;
		end else if (drain) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < ResMax; i++) begin
				buf_q[i] <= res_set.ent[i];
			end
		end
	end

	assign cur      = buf_q[rd_q];
	assign m_tvalid = (rem_q != '0);
	assign m_tdata  = {{(OutDataW-10){1'b0}}, cur.status, cur.out_byte};
	assign m_tuser  = cur.kind;
	assign m_tlast  = cur.last;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(ResMax))
		else $error("result buffer count out of range");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KindStatus && rem_q == 3'd1)
		else $error("status beat not final in buffer");

	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> rem_q == '0 || (drain && rem_q == 3'd1))
		else $error("buffer reloaded while beats pending");

	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_v_s1 && !step |=> in_v_s1 && $stable(byte_s1) && $stable(eof_s1))
		else $error("input stage lost a beat");

endmodule
